/* rtl/core/rrop_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rrop_pkg - shared types, constants and table builder
// Item layouts, arc-table entry format, bank status and the cos/sin ROM
// generator used by the rounded-rectangle outline unit.
// ============================================================================
package rrop_pkg;

    // Fixed widths
    localparam int COORD_W    = 14;   // input coordinates
    localparam int SIZE_W     = 13;   // width, height, screen height
    localparam int RAD_W      = 10;   // corner radius
    localparam int CTR_W      = 16;   // arc centers and intermediate sums
    localparam int POINT_W    = 15;   // output coordinates
    localparam int ROM_W      = 17;   // Q16 cos/sin, 1.0 = 65536
    localparam int PROD_W     = RAD_W + ROM_W;
    localparam int MAX_POINTS = 16;   // largest supported points per arc
    localparam int ARC_ADDR_W = 3;    // bank bit + arc slot

    // Fixed-point angle constants
    localparam logic [63:0] PI_Q28  = 64'd843314857;
    localparam logic [63:0] ONE_Q28 = 64'd268435456;

    // Corner arcs
    typedef enum logic [1:0] {
        ARC_TL = 2'd0,
        ARC_TR = 2'd1,
        ARC_BR = 2'd2,
        ARC_BL = 2'd3
    } arc_e;

    // One input item, unpacked from the stream
    typedef struct packed {
        logic [0:0]                clockwise;
        logic [0:0]                top_only;
        logic [RAD_W-1:0]          radius;
        logic [SIZE_W-1:0]         rect_height;
        logic [SIZE_W-1:0]         rect_width;
        logic signed [COORD_W-1:0] top_y;
        logic signed [COORD_W-1:0] left_x;
    } rect_req_t;

    // One arc-table entry: center, radius and offset signs
    typedef struct packed {
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic [RAD_W-1:0]        rad;
        logic                    neg_x;
        logic                    neg_y;
    } arc_entry_t;

    // Arc-table write port
    typedef struct packed {
        logic                  we;
        logic [ARC_ADDR_W-1:0] addr;
        arc_entry_t            data;
    } arc_wr_t;

    // Per-bank status handed from setup to the point sequencer
    typedef struct packed {
        logic [1:0] full;
        logic [1:0] rejected;
        logic [1:0] cw;
    } bank_status_t;

    // Emission slot to arc, for either direction
    function automatic arc_e arc_at(input logic cw, input logic [1:0] slot);
        arc_e a;
        unique case (slot)
            2'd0: a = ARC_BL;
            2'd1: a = cw ? ARC_TL : ARC_BR;
            2'd2: a = ARC_TR;
            2'd3: a = cw ? ARC_BR : ARC_TL;
        endcase
        return a;
    endfunction

    // Restoring divide, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q16 cos or sin of k*pi/(2n-1), series in Q28, rounded to nearest
    function automatic logic [ROM_W-1:0] rom_entry(input int n, input logic want_sin,
                                                   input int k);
        logic [63:0]        d;
        logic [63:0]        th;
        logic [63:0]        term;
        logic [63:0]        dv;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        d    = 64'(2 * n - 1);
        th   = udiv64(64'(k) * PI_Q28 + (d >> 1), d);
        term = want_sin ? th : ONE_Q28;
        sum  = $signed(term);
        for (int i = 1; i <= 14; i++) begin
            dv   = want_sin ? 64'((2 * i) * (2 * i + 1)) : 64'((2 * i - 1) * (2 * i));
            term = (term * th) >> 28;
            term = (term * th) >> 28;
            term = udiv64(term, dv);
            if ((i % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        rnd = ($unsigned(sum) + 64'd2048) >> 12;
        return rnd[ROM_W-1:0];
    endfunction

    // Whole table, entry k at bits [k*ROM_W +: ROM_W]
    function automatic logic [MAX_POINTS*ROM_W-1:0] rom_table(input int n,
                                                              input logic want_sin);
        logic [MAX_POINTS*ROM_W-1:0] t;
        t = '0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (k < n) begin
                t[k*ROM_W +: ROM_W] = rom_entry(n, want_sin, k);
            end
        end
        return t;
    endfunction

endpackage

/* rtl/core/rounded_rect_outline_points_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// rounded_rect_outline_points_unit - rounded rectangle outline generator
// Turns one rectangle request into its outline polygon, four corner arcs of
// POINTS_PER_ARC vertices each, last vertex flagged on tlast.
// ============================================================================
// Each accepted request yields 4*POINTS_PER_ARC output items (64 at the
// default), one per cycle while m_tready allows, or a single item with
// tuser set when the request is rejected; the point sequencer reads one
// arc-table entry and one cos/sin ROM entry per cycle, and that sets the
// rate. The arc table holds two banks, so the next request is taken and
// its arcs are prepared while the previous one is still streaming out;
// back-to-back accepted requests come out with no gap at the default size.
// tdata and tuser layouts are listed beside the ports.
// screen_height resets to 768 and is written through cfg_wr_en/cfg_wr_data.
module rounded_rect_outline_points_unit #(
    parameter int POINTS_PER_ARC = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,   // screen_height
    input  logic        s_tvalid,
    output logic        s_tready,
    // [13:0] left_x, [27:14] top_y, [40:28] rect_width, [53:41] rect_height,
    // [63:54] radius, [64] top_only, [65] clockwise, [71:66] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] point_x, [29:15] point_y, [31:30] zero
    output logic [31:0] m_tdata,
    output logic        m_tuser,       // [0] rejected
    output logic        m_tlast        // last_point
);

    rrop_pkg::rect_req_t    req;
    rrop_pkg::arc_wr_t      ram_wr;
    rrop_pkg::bank_status_t status;
    rrop_pkg::arc_entry_t   rd_data;
    logic [1:0]                          release_bank;
    logic                                rd_en;
    logic [rrop_pkg::ARC_ADDR_W-1:0]     rd_addr;
    logic [rrop_pkg::POINT_W-1:0]        point_x;
    logic [rrop_pkg::POINT_W-1:0]        point_y;

    // Unpack the input item
    assign req.left_x      = s_tdata[13:0];
    assign req.top_y       = s_tdata[27:14];
    assign req.rect_width  = s_tdata[40:28];
    assign req.rect_height = s_tdata[53:41];
    assign req.radius      = s_tdata[63:54];
    assign req.top_only    = s_tdata[64];
    assign req.clockwise   = s_tdata[65];

    rrop_setup u_setup (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .req          (req),
        .ram_wr       (ram_wr),
        .status       (status),
        .release_bank (release_bank)
    );

    rrop_arc_ram u_arc_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrop_point_gen #(
        .POINTS_PER_ARC (POINTS_PER_ARC)
    ) u_point_gen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .status       (status),
        .release_bank (release_bank),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .point_x      (point_x),
        .point_y      (point_y),
        .rejected     (m_tuser),
        .last_point   (m_tlast)
    );

    assign m_tdata = {2'b00, point_y, point_x};

endmodule

/* rtl/core/rrop_arc_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// rrop_arc_ram - arc descriptor table
// Two banks of four arc entries; one write port, one registered read port.
// ============================================================================
module rrop_arc_ram (
    input  logic                               aclk,
    input  rrop_pkg::arc_wr_t                  wr,
    input  logic                               rd_en,
    input  logic [rrop_pkg::ARC_ADDR_W-1:0]    rd_addr,
    output rrop_pkg::arc_entry_t               rd_data
);

    localparam int DEPTH = 1 << rrop_pkg::ARC_ADDR_W;

    rrop_pkg::arc_entry_t mem [DEPTH];
    rrop_pkg::arc_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/rrop_setup.sv */
`timescale 1ns / 1ps
// ============================================================================
// rrop_setup - request intake and arc table fill
// Holds one request, applies the rejection and clamp rules against the
// screen height, and if not rejected writes four arc entries to a free bank.
// ============================================================================
module rrop_setup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rrop_pkg::SIZE_W-1:0]       cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  rrop_pkg::rect_req_t               req,
    output rrop_pkg::arc_wr_t                 ram_wr,
    output rrop_pkg::bank_status_t            status,
    input  logic [1:0]                        release_bank
);

    localparam int CW = rrop_pkg::CTR_W;

    logic [rrop_pkg::SIZE_W-1:0]        sh_reg;
    logic                               busy_reg;
    logic [1:0]                         wcnt_reg;
    logic                               wbank_reg;
    logic [1:0]                         full_reg;
    logic [1:0]                         rejb_reg;
    logic [1:0]                         cwb_reg;
    logic signed [rrop_pkg::COORD_W-1:0] x_reg;
    logic signed [rrop_pkg::COORD_W-1:0] y_reg;
    logic [rrop_pkg::SIZE_W-1:0]        w_reg;
    logic [rrop_pkg::RAD_W-1:0]         r_reg;
    logic signed [CW-1:0]               ybot_reg;
    logic                               topo_reg;
    logic                               cw_reg;
    logic                               rej_reg;

    logic signed [CW-1:0] sh_ext;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_ytop;
    logic signed [CW-1:0] in_ysum;
    logic                 in_reject;
    logic                 in_clamp;
    logic                 accept;
    logic                 bank_free;
    logic                 write_ok;
    logic                 done;

    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;
    logic signed [CW-1:0] w_ext;
    logic signed [CW-1:0] r_ext;
    logic signed [CW-1:0] xl;
    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] xw;
    logic signed [CW-1:0] yt;
    logic signed [CW-1:0] yb;
    rrop_pkg::arc_e       arc;
    rrop_pkg::arc_entry_t entry;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    // Rejection and clamp on the incoming item
    always_comb begin
        sh_ext    = $signed({3'b000, sh_reg});
        in_y      = $signed({{2{req.top_y[rrop_pkg::COORD_W-1]}}, req.top_y});
        in_ytop   = in_y + $signed({6'd0, req.radius});
        in_ysum   = in_y + $signed({3'b000, req.rect_height});
        in_reject = in_ytop > sh_ext;
        in_clamp  = in_ysum > sh_ext;
    end

    // Screen height register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_reg <= rrop_pkg::SIZE_W'(768);
        end else if (cfg_wr_en) begin
            sh_reg <= cfg_wr_data;
        end
    end

    // Request holding register
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= req.left_x;
            y_reg    <= req.top_y;
            w_reg    <= req.rect_width;
            r_reg    <= req.radius;
            ybot_reg <= in_clamp ? sh_ext : in_ysum;
            topo_reg <= req.top_only[0] || in_clamp;
            cw_reg   <= req.clockwise[0];
            rej_reg  <= in_reject;
        end
    end

    // Fill sequencing
    always_comb begin
        bank_free = !full_reg[wbank_reg];
        write_ok  = busy_reg && bank_free && !rej_reg;
        done      = busy_reg && bank_free && (rej_reg || wcnt_reg == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            wcnt_reg  <= 2'd0;
            wbank_reg <= 1'b0;
            full_reg  <= 2'b00;
            rejb_reg  <= 2'b00;
            cwb_reg   <= 2'b00;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
                wcnt_reg <= 2'd0;
            end else if (done) begin
                busy_reg <= 1'b0;
            end else if (write_ok) begin
                wcnt_reg <= wcnt_reg + 2'd1;
            end
            for (int b = 0; b < 2; b++) begin
                if (release_bank[b]) begin
                    full_reg[b] <= 1'b0;
                end
            end
            if (done) begin
                full_reg[wbank_reg] <= 1'b1;
                rejb_reg[wbank_reg] <= rej_reg;
                cwb_reg[wbank_reg]  <= cw_reg;
                wbank_reg           <= !wbank_reg;
            end
        end
    end

    // Arc entry for the current slot
    always_comb begin
        x_ext = $signed({{2{x_reg[rrop_pkg::COORD_W-1]}}, x_reg});
        y_ext = $signed({{2{y_reg[rrop_pkg::COORD_W-1]}}, y_reg});
        w_ext = $signed({3'b000, w_reg});
        r_ext = $signed({6'd0, r_reg});
        xl    = x_ext + r_ext;
        xw    = x_ext + w_ext;
        xr    = xw - r_ext;
        yt    = y_ext + r_ext;
        yb    = ybot_reg - r_ext;
        arc   = rrop_pkg::arc_at(cw_reg, wcnt_reg);
        entry = '0;
        unique case (arc)
            rrop_pkg::ARC_TL: begin
                entry = '{cx: xl, cy: yt, rad: r_reg, neg_x: 1'b1, neg_y: 1'b1};
            end
            rrop_pkg::ARC_TR: begin
                entry = '{cx: xr, cy: yt, rad: r_reg, neg_x: 1'b0, neg_y: 1'b1};
            end
            rrop_pkg::ARC_BR: begin
                if (topo_reg) begin
                    entry = '{cx: xw, cy: ybot_reg, rad: '0, neg_x: 1'b0, neg_y: 1'b0};
                end else begin
                    entry = '{cx: xr, cy: yb, rad: r_reg, neg_x: 1'b0, neg_y: 1'b0};
                end
            end
            rrop_pkg::ARC_BL: begin
                if (topo_reg) begin
                    entry = '{cx: x_ext, cy: ybot_reg, rad: '0, neg_x: 1'b1, neg_y: 1'b0};
                end else begin
                    entry = '{cx: xl, cy: yb, rad: r_reg, neg_x: 1'b1, neg_y: 1'b0};
                end
            end
        endcase
    end

    assign ram_wr.we   = write_ok;
    assign ram_wr.addr = {wbank_reg, wcnt_reg};
    assign ram_wr.data = entry;

    assign status.full     = full_reg;
    assign status.rejected = rejb_reg;
    assign status.cw       = cwb_reg;

    // Never overwrite a bank the sequencer still owns
    a_write_free_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr.we |-> (busy_reg && !full_reg[wbank_reg]))
        else $error("arc table written into a full bank");

    // Once released, bank 0 is empty on the next cycle
    a_release_b0: assert property (@(posedge aclk) disable iff (!aresetn)
        release_bank[0] |=> !full_reg[0])
        else $error("bank 0 still full after release");

endmodule

/* rtl/core/rrop_point_gen.sv */
`timescale 1ns / 1ps
// ============================================================================
// rrop_point_gen - outline point sequencer and datapath
// Walks the arc table one point per cycle while the output is not stalled:
// table and ROM read, multiply, offset add with saturation, output register.
// ============================================================================
module rrop_point_gen #(
    parameter int POINTS_PER_ARC = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rrop_pkg::bank_status_t              status,
    output logic [1:0]                          release_bank,
    output logic                                rd_en,
    output logic [rrop_pkg::ARC_ADDR_W-1:0]     rd_addr,
    input  rrop_pkg::arc_entry_t                rd_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rrop_pkg::POINT_W-1:0]        point_x,
    output logic [rrop_pkg::POINT_W-1:0]        point_y,
    output logic                                rejected,
    output logic                                last_point
);

    localparam int RW = rrop_pkg::ROM_W;
    localparam int JW = $clog2(POINTS_PER_ARC);
    localparam logic [JW-1:0] LAST_PT = JW'(POINTS_PER_ARC - 1);
    localparam logic [rrop_pkg::MAX_POINTS*RW-1:0] COS_TBL =
        rrop_pkg::rom_table(POINTS_PER_ARC, 1'b0);
    localparam logic [rrop_pkg::MAX_POINTS*RW-1:0] SIN_TBL =
        rrop_pkg::rom_table(POINTS_PER_ARC, 1'b1);

    // Sequencer state
    logic          rbank_reg;
    logic [1:0]    arc_reg;
    logic [JW-1:0] pt_reg;

    // Stage B: table and ROM data
    logic          vb_reg;
    logic          rejb_reg;
    logic          lastb_reg;
    logic [RW-1:0] rom_c_reg;
    logic [RW-1:0] rom_s_reg;

    // Stage C: products
    logic                             vc_reg;
    logic                             rejc_reg;
    logic                             lastc_reg;
    logic [rrop_pkg::PROD_W-1:0]      prod_x_reg;
    logic [rrop_pkg::PROD_W-1:0]      prod_y_reg;
    logic signed [rrop_pkg::CTR_W-1:0] cx_reg;
    logic signed [rrop_pkg::CTR_W-1:0] cy_reg;
    logic                             negx_reg;
    logic                             negy_reg;

    // Stage D: output register
    logic                         vd_reg;
    logic                         rejd_reg;
    logic                         lastd_reg;
    logic [rrop_pkg::POINT_W-1:0] px_reg;
    logic [rrop_pkg::POINT_W-1:0] py_reg;

    logic          en;
    logic          cur_full;
    logic          cur_rej;
    logic          cur_cw;
    logic          issue;
    logic          last_pt;
    logic          seq_done;
    logic          forward;
    logic [JW-1:0] k;

    logic [rrop_pkg::RAD_W-1:0]       dx;
    logic [rrop_pkg::RAD_W-1:0]       dy;
    logic signed [rrop_pkg::CTR_W:0]  sum_x;
    logic signed [rrop_pkg::CTR_W:0]  sum_y;

    function automatic logic [rrop_pkg::POINT_W-1:0] sat15(
        input logic signed [rrop_pkg::CTR_W:0] v);
        logic [rrop_pkg::POINT_W-1:0] r;
        if (v > 17'sd16383) begin
            r = 15'h3FFF;
        end else if (v < -17'sd16384) begin
            r = 15'h4000;
        end else begin
            r = v[rrop_pkg::POINT_W-1:0];
        end
        return r;
    endfunction

    // Issue control
    always_comb begin
        en       = !vd_reg || m_tready;
        cur_full = status.full[rbank_reg];
        cur_rej  = status.rejected[rbank_reg];
        cur_cw   = status.cw[rbank_reg];
        issue    = en && cur_full;
        last_pt  = (arc_reg == 2'd3) && (pt_reg == LAST_PT);
        seq_done = issue && (cur_rej || last_pt);
        forward  = (arc_reg[0] == cur_cw);
        k        = forward ? pt_reg : (LAST_PT - pt_reg);
        release_bank[0] = seq_done && !rbank_reg;
        release_bank[1] = seq_done && rbank_reg;
        rd_en   = en;
        rd_addr = {rbank_reg, arc_reg};
    end

    // Point counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rbank_reg <= 1'b0;
            arc_reg   <= 2'd0;
            pt_reg    <= '0;
        end else if (issue) begin
            if (seq_done) begin
                rbank_reg <= !rbank_reg;
                arc_reg   <= 2'd0;
                pt_reg    <= '0;
            end else if (pt_reg == LAST_PT) begin
                arc_reg <= arc_reg + 2'd1;
                pt_reg  <= '0;
            end else begin
                pt_reg <= pt_reg + JW'(1);
            end
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= cur_full;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // Stage B: ROM read alongside the table read
    always_ff @(posedge aclk) begin
        if (en) begin
            rejb_reg  <= cur_rej;
            lastb_reg <= cur_rej || last_pt;
            rom_c_reg <= COS_TBL[k*RW +: RW];
            rom_s_reg <= SIN_TBL[k*RW +: RW];
        end
    end

    // Stage C: radius times cos and sin
    always_ff @(posedge aclk) begin
        if (en) begin
            rejc_reg   <= rejb_reg;
            lastc_reg  <= lastb_reg;
            prod_x_reg <= rd_data.rad * rom_c_reg;
            prod_y_reg <= rd_data.rad * rom_s_reg;
            cx_reg     <= rd_data.cx;
            cy_reg     <= rd_data.cy;
            negx_reg   <= rd_data.neg_x;
            negy_reg   <= rd_data.neg_y;
        end
    end

    // Offset add and saturation
    always_comb begin
        dx    = prod_x_reg[16 +: rrop_pkg::RAD_W];
        dy    = prod_y_reg[16 +: rrop_pkg::RAD_W];
        sum_x = negx_reg ? ({cx_reg[rrop_pkg::CTR_W-1], cx_reg} - $signed({7'd0, dx}))
                         : ({cx_reg[rrop_pkg::CTR_W-1], cx_reg} + $signed({7'd0, dx}));
        sum_y = negy_reg ? ({cy_reg[rrop_pkg::CTR_W-1], cy_reg} - $signed({7'd0, dy}))
                         : ({cy_reg[rrop_pkg::CTR_W-1], cy_reg} + $signed({7'd0, dy}));
    end

    // Stage D: output register
    always_ff @(posedge aclk) begin
        if (en) begin
            rejd_reg  <= rejc_reg;
            lastd_reg <= lastc_reg;
            px_reg    <= rejc_reg ? '0 : sat15(sum_x);
            py_reg    <= rejc_reg ? '0 : sat15(sum_y);
        end
    end

    assign m_tvalid   = vd_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign rejected   = rejd_reg;
    assign last_point = lastd_reg;

    // A rejected item is alone and carries no coordinates
    a_reject_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (vd_reg && rejd_reg) |-> (lastd_reg && px_reg == '0 && py_reg == '0))
        else $error("rejected item malformed");

    // Mid-run, the bank being walked stays full
    a_bank_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (arc_reg != 2'd0 || pt_reg != '0) |-> status.full[rbank_reg])
        else $error("bank released during a run");

    // The counter restarts after the final point of a request
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_done |=> (arc_reg == 2'd0 && pt_reg == '0 && rbank_reg != $past(rbank_reg)))
        else $error("point counter not restarted");

endmodule
